FILE: hdl/kbc_pkg.sv
// shared types, constants and run-summary functions for the k-mer composition scorer
package kbc_pkg;

	localparam int MAX_BASES     = 32;
	localparam int BASES_IN_WORD = 32;
	localparam int EFF_BASES     = (MAX_BASES < BASES_IN_WORD) ? MAX_BASES : BASES_IN_WORD;
	localparam int NUM_LANES     = 4;
	localparam int LANE_BASES    = BASES_IN_WORD / NUM_LANES;
	localparam int LEN_W         = 6;
	localparam int KMER_W        = 2 * BASES_IN_WORD;
	localparam int COUNT_W       = 32;
	localparam int GC_LANE_W     = $clog2(LANE_BASES + 1);

	// base codes
	localparam logic [1:0] BASE_A = 2'b00;
	localparam logic [1:0] BASE_C = 2'b01;
	localparam logic [1:0] BASE_T = 2'b10;
	localparam logic [1:0] BASE_G = 2'b11;

	// one run of a base class: length and which of the two kinds it holds
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             has_x;
		logic             has_y;
	} run_t;

	// summary of a stretch of bases for one class
	typedef struct packed {
		logic             all;
		run_t             pre;
		run_t             suf;
		logic [LEN_W-1:0] mid;
	} run_sum_t;

	function automatic run_t run_join(run_t a, run_t b);
		run_t j;
		j.len   = a.len + b.len;
		j.has_x = a.has_x | b.has_x;
		j.has_y = a.has_y | b.has_y;
		return j;
	endfunction

	// a run scores its length only when it holds both kinds
	function automatic logic [LEN_W-1:0] run_score(run_t r);
		return (r.has_x && r.has_y) ? r.len : '0;
	endfunction

	function automatic run_sum_t run_identity();
		run_sum_t s;
		s     = '0;
		s.all = 1'b1;
		return s;
	endfunction

	// single base: either part of the class or a run breaker
	function automatic run_sum_t run_leaf(logic in_class, logic is_x);
		run_sum_t s;
		s = '0;
		if (in_class) begin
			s.all       = 1'b1;
			s.pre.len   = LEN_W'(1);
			s.pre.has_x = is_x;
			s.pre.has_y = ~is_x;
			s.suf       = s.pre;
		end
		return s;
	endfunction

	// concatenate two adjacent stretches, left one first
	function automatic run_sum_t run_merge(run_sum_t l, run_sum_t r);
		run_sum_t m;
		m = '0;
		priority if (l.all && r.all) begin
			m.all = 1'b1;
			m.pre = run_join(l.pre, r.pre);
			m.suf = m.pre;
			m.mid = '0;
		end else if (l.all) begin
			m.pre = run_join(l.pre, r.pre);
			m.suf = r.suf;
			m.mid = r.mid;
		end else if (r.all) begin
			m.pre = l.pre;
			m.suf = run_join(l.suf, r.pre);
			m.mid = l.mid;
		end else begin
			m.pre = l.pre;
			m.suf = r.suf;
			m.mid = l.mid + r.mid + run_score(run_join(l.suf, r.pre));
		end
		return m;
	endfunction

	// close the open runs at both ends
	function automatic logic [LEN_W-1:0] run_total(run_sum_t s);
		logic [LEN_W-1:0] t;
		t = s.mid + run_score(s.pre);
		if (!s.all) begin
			t = t + run_score(s.suf);
		end
		return t;
	endfunction

endpackage

FILE: hdl/kbc_lane.sv
// one lane: run summaries and gc count over a slice of bases
module kbc_lane (
	input  logic                              clk,
	input  logic [2*kbc_pkg::LANE_BASES-1:0]  seg_bits,
	input  logic [kbc_pkg::LANE_BASES-1:0]    seg_valid,
	output kbc_pkg::run_sum_t                 pur_s2,
	output kbc_pkg::run_sum_t                 pyr_s2,
	output logic [kbc_pkg::GC_LANE_W-1:0]     gc_s2
);
	import kbc_pkg::*;

	run_sum_t             pur_d;
	run_sum_t             pyr_d;
	logic [GC_LANE_W-1:0] gc_d;

	// fold the bases of the slice in order
	always_comb begin
		logic [1:0] b;
		logic       pu;
		pur_d = run_identity();
		pyr_d = run_identity();
		gc_d  = '0;
		for (int i = 0; i < LANE_BASES; i++) begin
			b  = seg_bits[2*i +: 2];
			pu = (b == BASE_A) || (b == BASE_G);
			pur_d = run_merge(pur_d, run_leaf(seg_valid[i] && pu, b == BASE_A));
			pyr_d = run_merge(pyr_d, run_leaf(seg_valid[i] && !pu, b == BASE_C));
			if (seg_valid[i] && ((b == BASE_C) || (b == BASE_G))) begin
				gc_d = gc_d + GC_LANE_W'(1);
			end
		end
	end

	// lane result register
	always_ff @(posedge clk) begin
		pur_s2 <= pur_d;
		pyr_s2 <= pyr_d;
		gc_s2  <= gc_d;
	end

endmodule

FILE: hdl/kbc_merge.sv
// merge stage: joins lane summaries and registers the final scores
module kbc_merge (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             vld_s2,
	input  logic [kbc_pkg::COUNT_W-1:0]                      count_s2,
	input  kbc_pkg::run_sum_t [kbc_pkg::NUM_LANES-1:0]       pur_s2,
	input  kbc_pkg::run_sum_t [kbc_pkg::NUM_LANES-1:0]       pyr_s2,
	input  logic [kbc_pkg::NUM_LANES-1:0][kbc_pkg::GC_LANE_W-1:0] gc_s2,
	output logic                                             done,
	output logic [kbc_pkg::LEN_W-1:0]                        gc_score,
	output logic [kbc_pkg::LEN_W-1:0]                        purine_score,
	output logic [kbc_pkg::LEN_W-1:0]                        pyrimidine_score,
	output logic [kbc_pkg::LEN_W-1:0]                        combined_score,
	output logic [kbc_pkg::COUNT_W-1:0]                      count_out
);
	import kbc_pkg::*;

	logic [LEN_W-1:0] gc_d;
	logic [LEN_W-1:0] pur_d;
	logic [LEN_W-1:0] pyr_d;

	// join lanes from the low end and close the outer runs
	always_comb begin
		run_sum_t pur_all;
		run_sum_t pyr_all;
		pur_all = run_identity();
		pyr_all = run_identity();
		gc_d    = '0;
		for (int l = 0; l < NUM_LANES; l++) begin
			pur_all = run_merge(pur_all, pur_s2[l]);
			pyr_all = run_merge(pyr_all, pyr_s2[l]);
			gc_d    = gc_d + LEN_W'(gc_s2[l]);
		end
		pur_d = run_total(pur_all);
		pyr_d = run_total(pyr_all);
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s2;
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		gc_score         <= gc_d;
		purine_score     <= pur_d;
		pyrimidine_score <= pyr_d;
		combined_score   <= (pur_d > pyr_d) ? pur_d : pyr_d;
		count_out        <= count_s2;
	end

endmodule

FILE: hdl/kmer_base_composition_score.sv
// top level of the k-mer base composition scorer
// an accepted k-mer reaches its done beat through the s1, s2 and merge output registers
// throughput: one k-mer per cycle, busy stays low, results cannot be stalled
// four lanes of eight bases each work in the second stage, then one merge stage
// reset clears the pipeline strobes and sets mer_size to 32
module kmer_base_composition_score (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [kbc_pkg::KMER_W-1:0]     kmer_bits,
	input  logic [kbc_pkg::COUNT_W-1:0]    count_value,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kbc_pkg::LEN_W-1:0]      cfg_data,
	output logic                           done,
	output logic [kbc_pkg::LEN_W-1:0]      gc_score,
	output logic [kbc_pkg::LEN_W-1:0]      purine_score,
	output logic [kbc_pkg::LEN_W-1:0]      pyrimidine_score,
	output logic [kbc_pkg::LEN_W-1:0]      combined_score,
	output logic [kbc_pkg::COUNT_W-1:0]    count_out
);
	import kbc_pkg::*;

	logic [LEN_W-1:0]         mer_q;
	logic [LEN_W-1:0]         len_eff;
	logic [BASES_IN_WORD-1:0] mask_d;

	logic                     vld_s1;
	logic                     vld_s2;
	logic [KMER_W-1:0]        kmer_s1;
	logic [BASES_IN_WORD-1:0] mask_s1;
	logic [COUNT_W-1:0]       count_s1;
	logic [COUNT_W-1:0]       count_s2;

	run_sum_t [NUM_LANES-1:0]            pur_s2;
	run_sum_t [NUM_LANES-1:0]            pyr_s2;
	logic [NUM_LANES-1:0][GC_LANE_W-1:0] gc_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mer_q <= LEN_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			mer_q <= cfg_data;
		end
	end

	// examined length and per-base valid mask
	always_comb begin
		len_eff = (mer_q > LEN_W'(EFF_BASES)) ? LEN_W'(EFF_BASES) : mer_q;
		for (int i = 0; i < BASES_IN_WORD; i++) begin
			mask_d[i] = LEN_W'(i) < len_eff;
		end
	end

	// pipeline strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	// input beat capture and count delay
	always_ff @(posedge clk) begin
		kmer_s1  <= kmer_bits;
		mask_s1  <= mask_d;
		count_s1 <= count_value;
		count_s2 <= count_s1;
	end

	// lanes
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		kbc_lane u_lane (
			.clk       (clk),
			.seg_bits  (kmer_s1[l*2*LANE_BASES +: 2*LANE_BASES]),
			.seg_valid (mask_s1[l*LANE_BASES +: LANE_BASES]),
			.pur_s2    (pur_s2[l]),
			.pyr_s2    (pyr_s2[l]),
			.gc_s2     (gc_s2[l])
		);
	end

	kbc_merge u_merge (
		.clk              (clk),
		.arst_n           (arst_n),
		.vld_s2           (vld_s2),
		.count_s2         (count_s2),
		.pur_s2           (pur_s2),
		.pyr_s2           (pyr_s2),
		.gc_s2            (gc_s2),
		.done             (done),
		.gc_score         (gc_score),
		.purine_score     (purine_score),
		.pyrimidine_score (pyrimidine_score),
		.combined_score   (combined_score),
		.count_out        (count_out)
	);

endmodule
